### rtl/ieps_pkg.sv
// shared types, constants and address helpers for the eeprom page write sequencer
`timescale 1ns / 1ps

package ieps_pkg;

  localparam int ADDR_WIDTH = 18;
  localparam int LEN_WIDTH  = 16;
  localparam int CFG_WIDTH  = 8;
  localparam int IDX_WIDTH  = 3;
  localparam int CHUNK_WIDTH = 9;
  localparam logic [3:0] MAX_PAGE_LOG2 = 4'd8;

  typedef enum logic [IDX_WIDTH-1:0] {
    REG_PAGE_SIZE_LOG2 = 3'd0,
    REG_ADDR_BYTES     = 3'd1,
    REG_HIGH_ADDR_BITS = 3'd2,
    REG_DEVICE_ADDR    = 3'd3,
    REG_POLL_ATTEMPTS  = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_WRITE   = 2'd0,
    MODE_READ    = 2'd1,
    MODE_OUTCOME = 2'd2,
    MODE_TICK    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_POLL  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_DONE  = 2'd3
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_WRITE = 5'b00010,
    PH_POLL  = 5'b00100,
    PH_TICK  = 5'b01000,
    PH_READ  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [3:0] page_size_log2;
    logic [1:0] addr_bytes;
    logic [1:0] high_addr_bits;
    logic [6:0] device_addr;
    logic [7:0] poll_attempts;
  } cfg_t;

  typedef struct packed {
    cmd_t        command;
    logic [6:0]  bus_addr;
    logic [15:0] addr_field;
    logic [15:0] byte_count;
    logic [15:0] source_offset;
    logic        status;
  } word_t;

  // device address with the memory address bits above the address bytes
  function automatic logic [6:0] bus_addr_of(logic [ADDR_WIDTH-1:0] pos, cfg_t cfg);
    logic [31:0] posx;
    logic [31:0] hi;
    logic [2:0]  mask;
    posx = 32'(pos);
    hi   = cfg.addr_bytes[1] ? (posx >> 16) : (posx >> 8);
    case (cfg.high_addr_bits)
      2'd0:    mask = 3'b000;
      2'd1:    mask = 3'b001;
      2'd2:    mask = 3'b011;
      default: mask = 3'b111;
    endcase
    return cfg.device_addr | {4'b0000, hi[2:0] & mask};
  endfunction

  // memory address bytes, low byte only in one-byte mode
  function automatic logic [15:0] addr_field_of(logic [ADDR_WIDTH-1:0] pos, cfg_t cfg);
    logic [31:0] posx;
    posx = 32'(pos);
    return cfg.addr_bytes[1] ? posx[15:0] : {8'h00, posx[7:0]};
  endfunction

endpackage

### rtl/ieps_core.sv
// request state and per-word command generation
`timescale 1ns / 1ps

module ieps_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               accept,
  input  logic [1:0]                         mode,
  input  logic [ieps_pkg::ADDR_WIDTH-1:0]    mem_addr,
  input  logic [ieps_pkg::LEN_WIDTH-1:0]     length,
  input  logic                               trans_ok,
  input  ieps_pkg::cfg_t                     cfg,
  output logic                               res_valid,
  output ieps_pkg::word_t                    res
);

  ieps_pkg::phase_t                      phase, phase_next;
  logic [ieps_pkg::ADDR_WIDTH-1:0]       position, position_next;
  logic [ieps_pkg::LEN_WIDTH-1:0]        remaining, remaining_next;
  logic [15:0]                           buffer_offset, buffer_offset_next;
  logic [ieps_pkg::CHUNK_WIDTH-1:0]      chunk_length, chunk_length_next;
  logic [7:0]                            attempts_left, attempts_left_next;

  logic [ieps_pkg::ADDR_WIDTH-1:0]  adv_pos, ch_pos;
  logic [ieps_pkg::LEN_WIDTH-1:0]   adv_rem, ch_rem;
  logic [15:0]                      adv_off, ch_off;
  logic [3:0]                       lg;
  logic [ieps_pkg::CHUNK_WIDTH-1:0] page, cnt;
  logic [31:0]                      ch_posx;
  logic [7:0]                       att_dec;
  logic                             is_outcome;

  // position after a chunk completes
  assign adv_pos = ieps_pkg::ADDR_WIDTH'(32'(position) + 32'(chunk_length));
  assign adv_rem = ieps_pkg::LEN_WIDTH'(32'(remaining) - 32'(chunk_length));
  assign adv_off = 16'(32'(buffer_offset) + 32'(chunk_length));

  // next chunk starts from the request or from the advanced position
  assign ch_pos  = (phase == ieps_pkg::PH_POLL) ? adv_pos : mem_addr;
  assign ch_rem  = (phase == ieps_pkg::PH_POLL) ? adv_rem : length;
  assign ch_off  = (phase == ieps_pkg::PH_POLL) ? adv_off : 16'h0000;
  assign ch_posx = 32'(ch_pos);

  assign lg   = (cfg.page_size_log2 > ieps_pkg::MAX_PAGE_LOG2) ?
                ieps_pkg::MAX_PAGE_LOG2 : cfg.page_size_log2;
  assign page = ieps_pkg::CHUNK_WIDTH'(1) << lg;

  always_comb begin
    logic [ieps_pkg::CHUNK_WIDTH-1:0] to_end;
    to_end = page - (ch_posx[ieps_pkg::CHUNK_WIDTH-1:0] & (page - 1'b1));
    if (32'(to_end) > 32'(ch_rem)) begin
      cnt = ieps_pkg::CHUNK_WIDTH'(32'(ch_rem));
    end else begin
      cnt = to_end;
    end
  end

  assign att_dec    = attempts_left - 8'd1;
  assign is_outcome = (mode == ieps_pkg::MODE_OUTCOME);

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    remaining_next     = remaining;
    buffer_offset_next = buffer_offset;
    chunk_length_next  = chunk_length;
    attempts_left_next = attempts_left;
    res_valid          = 1'b0;
    res                = '0;

    if (accept) begin
      case (phase)
        ieps_pkg::PH_IDLE: begin
          if (mode == ieps_pkg::MODE_WRITE) begin
            position_next      = mem_addr;
            remaining_next     = length;
            buffer_offset_next = 16'h0000;
            res_valid          = 1'b1;
            if (length == '0) begin
              res.command = ieps_pkg::CMD_DONE;
            end else begin
              chunk_length_next = cnt;
              phase_next        = ieps_pkg::PH_WRITE;
              res.command       = ieps_pkg::CMD_WRITE;
              res.bus_addr      = ieps_pkg::bus_addr_of(ch_pos, cfg);
              res.addr_field    = ieps_pkg::addr_field_of(ch_pos, cfg);
              res.byte_count    = 16'(cnt);
              res.source_offset = ch_off;
            end
          end else if (mode == ieps_pkg::MODE_READ) begin
            position_next      = mem_addr;
            remaining_next     = length;
            buffer_offset_next = 16'h0000;
            phase_next         = ieps_pkg::PH_READ;
            res_valid          = 1'b1;
            res.command        = ieps_pkg::CMD_READ;
            res.bus_addr       = ieps_pkg::bus_addr_of(mem_addr, cfg);
            res.addr_field     = ieps_pkg::addr_field_of(mem_addr, cfg);
            res.byte_count     = 16'(32'(length));
          end
        end
        ieps_pkg::PH_WRITE: begin
          if (is_outcome) begin
            res_valid = 1'b1;
            if (!trans_ok) begin
              phase_next  = ieps_pkg::PH_IDLE;
              res.command = ieps_pkg::CMD_DONE;
              res.status  = 1'b1;
            end else begin
              attempts_left_next = (cfg.poll_attempts == 8'd0) ? 8'd1 : cfg.poll_attempts;
              phase_next         = ieps_pkg::PH_POLL;
              res.command        = ieps_pkg::CMD_POLL;
              res.bus_addr       = ieps_pkg::bus_addr_of(position, cfg);
              res.byte_count     = 16'd1;
            end
          end
        end
        ieps_pkg::PH_POLL: begin
          if (is_outcome) begin
            if (trans_ok) begin
              position_next      = adv_pos;
              remaining_next     = adv_rem;
              buffer_offset_next = adv_off;
              res_valid          = 1'b1;
              if (adv_rem == '0) begin
                phase_next  = ieps_pkg::PH_IDLE;
                res.command = ieps_pkg::CMD_DONE;
              end else begin
                chunk_length_next = cnt;
                phase_next        = ieps_pkg::PH_WRITE;
                res.command       = ieps_pkg::CMD_WRITE;
                res.bus_addr      = ieps_pkg::bus_addr_of(ch_pos, cfg);
                res.addr_field    = ieps_pkg::addr_field_of(ch_pos, cfg);
                res.byte_count    = 16'(cnt);
                res.source_offset = ch_off;
              end
            end else begin
              attempts_left_next = att_dec;
              if (att_dec == 8'd0) begin
                phase_next  = ieps_pkg::PH_IDLE;
                res_valid   = 1'b1;
                res.command = ieps_pkg::CMD_DONE;
                res.status  = 1'b1;
              end else begin
                phase_next = ieps_pkg::PH_TICK;
              end
            end
          end
        end
        ieps_pkg::PH_TICK: begin
          if (mode == ieps_pkg::MODE_TICK) begin
            phase_next     = ieps_pkg::PH_POLL;
            res_valid      = 1'b1;
            res.command    = ieps_pkg::CMD_POLL;
            res.bus_addr   = ieps_pkg::bus_addr_of(position, cfg);
            res.byte_count = 16'd1;
          end
        end
        ieps_pkg::PH_READ: begin
          if (is_outcome) begin
            phase_next  = ieps_pkg::PH_IDLE;
            res_valid   = 1'b1;
            res.command = ieps_pkg::CMD_DONE;
            res.status  = !trans_ok;
          end
        end
        default: begin
          phase_next = ieps_pkg::PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= ieps_pkg::PH_IDLE;
      position      <= '0;
      remaining     <= '0;
      buffer_offset <= '0;
      chunk_length  <= '0;
      attempts_left <= '0;
    end else begin
      phase         <= phase_next;
      position      <= position_next;
      remaining     <= remaining_next;
      buffer_offset <= buffer_offset_next;
      chunk_length  <= chunk_length_next;
      attempts_left <= attempts_left_next;
    end
  end

endmodule

### rtl/ieps_obuf.sv
// output register with one skid entry
`timescale 1ns / 1ps

module ieps_obuf (
  input  logic            clk,
  input  logic            rst,
  input  logic            res_valid,
  input  ieps_pkg::word_t res,
  input  logic            out_stall,
  output logic            out_valid,
  output ieps_pkg::word_t out_word,
  output logic            full
);

  logic            ov, sv;
  ieps_pkg::word_t oword, sword;
  logic            drain;

  assign drain     = !ov || !out_stall;
  assign out_valid = ov;
  assign out_word  = oword;
  assign full      = sv;

  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
      sv <= 1'b0;
    end else if (drain) begin
      if (sv) begin
        ov <= 1'b1;
        sv <= res_valid;
      end else begin
        ov <= res_valid;
      end
    end else if (res_valid) begin
      sv <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      if (sv) begin
        oword <= sword;
        if (res_valid) begin
          sword <= res;
        end
      end else if (res_valid) begin
        oword <= res;
      end
    end else if (res_valid) begin
      sword <= res;
    end
  end

endmodule

### rtl/i2c_eeprom_page_write_sequencer.sv
// top level of the i2c eeprom page write sequencer with ack polling
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  mode, mem_addr, length, trans_ok
//   out      from block out_valid / out_stall command, bus_addr, addr_field,
//                                            byte_count, source_offset, status
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// one word is taken per cycle while in_stall is low; its command word, if any,
// is registered in the output register or in its skid entry
// the state update and command build are one combinational pass between the
// request state registers and the output register
// in_stall rises only when the output register and its skid entry are both
// full, so one stalled result never blocks the next input word
// rst is synchronous; it clears the request state, the output queue and the
// config registers to their defaults
`timescale 1ns / 1ps

module i2c_eeprom_page_write_sequencer (
  input  logic                                  clk,
  input  logic                                  rst,
  // input word channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            mode,
  input  logic [ieps_pkg::ADDR_WIDTH-1:0]       mem_addr,
  input  logic [ieps_pkg::LEN_WIDTH-1:0]        length,
  input  logic                                  trans_ok,
  // output word channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            command,
  output logic [6:0]                            bus_addr,
  output logic [15:0]                           addr_field,
  output logic [15:0]                           byte_count,
  output logic [15:0]                           source_offset,
  output logic                                  status,
  // config write port
  input  logic                                  cfg_we,
  input  logic [ieps_pkg::IDX_WIDTH-1:0]        cfg_index,
  input  logic [ieps_pkg::CFG_WIDTH-1:0]        cfg_data
);

  ieps_pkg::cfg_t  cfg;
  ieps_pkg::word_t res, out_word;
  logic            res_valid;
  logic            accept;
  logic            full;

  // config registers, indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.page_size_log2 <= 4'd3;
      cfg.addr_bytes     <= 2'd1;
      cfg.high_addr_bits <= 2'd0;
      cfg.device_addr    <= 7'd80;
      cfg.poll_attempts  <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        ieps_pkg::REG_PAGE_SIZE_LOG2: cfg.page_size_log2 <= cfg_data[3:0];
        ieps_pkg::REG_ADDR_BYTES:     cfg.addr_bytes     <= cfg_data[1:0];
        ieps_pkg::REG_HIGH_ADDR_BITS: cfg.high_addr_bits <= cfg_data[1:0];
        ieps_pkg::REG_DEVICE_ADDR:    cfg.device_addr    <= cfg_data[6:0];
        ieps_pkg::REG_POLL_ATTEMPTS:  cfg.poll_attempts  <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // input is held off only while the skid entry is occupied
  assign in_stall = full;
  assign accept   = in_valid && !full;

  ieps_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .mem_addr  (mem_addr),
    .length    (length),
    .trans_ok  (trans_ok),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  ieps_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .full      (full)
  );

  // unpack the output word onto the field ports
  assign command       = out_word.command;
  assign bus_addr      = out_word.bus_addr;
  assign addr_field    = out_word.addr_field;
  assign byte_count    = out_word.byte_count;
  assign source_offset = out_word.source_offset;
  assign status        = out_word.status;

endmodule
